// File: rtl/uart_rx_handshake_parity_assert.svh
// ---------------------------------------------------------------------------
// uart receiver assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef UART_RX_HANDSHAKE_PARITY_ASSERT_SVH
`define UART_RX_HANDSHAKE_PARITY_ASSERT_SVH
`ifndef SYNTHESIS
`define URXHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("urxhp assertion failed");
`define URXHP_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("urxhp forbidden condition seen");
`else
`define URXHP_ASSERT(lbl, prop)
`define URXHP_NEVER(lbl, expr)
`endif
`endif

// File: rtl/urxhp_pkg.sv
// ---------------------------------------------------------------------------
// urxhp_pkg
// shared constants and types of the uart receiver
// ---------------------------------------------------------------------------
package urxhp_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 64;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_ODD    = 2'd1;

  localparam logic [15:0] TPB_RESET = 16'd868;
  localparam logic [15:0] TPB_MIN   = 16'd2;
  localparam logic [15:0] CNT_MAX   = 16'hFFFF;

  localparam logic [7:0] LINE_FEED = 8'h0A;
  localparam logic [7:0] BYTE_MASK = 8'h7F;
  localparam logic [3:0] LAST_BIT  = 4'd8;

  typedef enum logic [2:0] {
    TRAP_NONE     = 3'd0,
    TRAP_RX_LOW   = 3'd1,
    TRAP_RTS_HIGH = 3'd2,
    TRAP_BAD_STOP = 3'd3,
    TRAP_RTS_DROP = 3'd4
  } trap_e;

  typedef struct packed {
    logic [15:0] ticks_per_bit;
    logic        parity_odd;
  } cfg_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } push_t;

  typedef struct packed {
    logic  cts;
    logic  perr;
    trap_e trap;
  } frm_stat_t;

  typedef struct packed {
    logic       pop_valid;
    logic [7:0] pop_byte;
    logic       nonempty;
    logic       overflow;
  } fifo_stat_t;

  typedef struct packed {
    logic       cts_level;
    logic       pop_valid;
    logic [7:0] pop_byte;
    logic       fifo_nonempty;
    logic       overflow_flag;
    logic       parity_error;
    logic [2:0] trap_code;
  } res_t;

endpackage

// File: rtl/uart_rx_handshake_parity.sv
// ---------------------------------------------------------------------------
// uart_rx_handshake_parity
// uart receiver with rts/cts flow control, parity check and receive fifo
// one item per cycle while in_ready_o is high; its result is registered
// a two-entry output stage keeps taking items while one result waits
// reset: receiver at start check, fifo empty, cts low, config at defaults
// ---------------------------------------------------------------------------
`include "uart_rx_handshake_parity_assert.svh"

module uart_rx_handshake_parity #(
  parameter int unsigned FIFO_DEPTH = urxhp_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [urxhp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [urxhp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             rx_level_i,
  input  logic                             rts_level_i,
  input  logic                             pop_request_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             cts_level_o,
  output logic                             pop_valid_o,
  output logic [7:0]                       pop_byte_o,
  output logic                             fifo_nonempty_o,
  output logic                             overflow_flag_o,
  output logic                             parity_error_o,
  output logic [2:0]                       trap_code_o
);
  import urxhp_pkg::*;

  cfg_t       cfg_q;
  frm_stat_t  frm_stat;
  fifo_stat_t fifo_stat;
  push_t      push;
  res_t       res_d, out_q, skid_q;
  logic       out_valid_q, skid_valid_q;
  logic       in_fire, out_take;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_take   = out_valid_q && out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ticks_per_bit: TPB_RESET, parity_odd: 1'b0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TICKS_PER_BIT: cfg_q.ticks_per_bit <= cfg_data_i;
        REG_PARITY_ODD:    cfg_q.parity_odd    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  urxhp_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (in_fire),
    .pop_req_i (pop_request_i),
    .push_i    (push),
    .stat_o    (fifo_stat)
  );

  urxhp_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (in_fire),
    .rx_level_i  (rx_level_i),
    .rts_level_i (rts_level_i),
    .cfg_i       (cfg_q),
    .push_o      (push),
    .stat_o      (frm_stat)
  );

  always_comb begin
    res_d.cts_level     = frm_stat.cts;
    res_d.pop_valid     = fifo_stat.pop_valid;
    res_d.pop_byte      = fifo_stat.pop_byte;
    res_d.fifo_nonempty = fifo_stat.nonempty;
    res_d.overflow_flag = fifo_stat.overflow;
    res_d.parity_error  = frm_stat.perr;
    res_d.trap_code     = frm_stat.trap;
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_take) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cts_level_o     = out_q.cts_level;
  assign pop_valid_o     = out_q.pop_valid;
  assign pop_byte_o      = out_q.pop_byte;
  assign fifo_nonempty_o = out_q.fifo_nonempty;
  assign overflow_flag_o = out_q.overflow_flag;
  assign parity_error_o  = out_q.parity_error;
  assign trap_code_o     = out_q.trap_code;

  `URXHP_NEVER(a_skid_without_out, skid_valid_q && !out_valid_q)
  `URXHP_ASSERT(a_pop_needs_item, !in_fire |-> !fifo_stat.pop_valid)
  `URXHP_ASSERT(a_trap_sticky, (frm_stat.trap != TRAP_NONE) |=> $stable(frm_stat.trap))
  `URXHP_ASSERT(a_overflow_sticky, fifo_stat.overflow |=> fifo_stat.overflow)

endmodule

// File: rtl/urxhp_ram.sv
// ---------------------------------------------------------------------------
// urxhp_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module urxhp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/urxhp_fifo.sv
// ---------------------------------------------------------------------------
// urxhp_fifo
// ring fifo of received bytes, pop before push, sticky overflow
// ---------------------------------------------------------------------------
module urxhp_fifo #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   pop_req_i,
  input  urxhp_pkg::push_t       push_i,
  output urxhp_pkg::fifo_stat_t  stat_o
);
  import urxhp_pkg::*;

  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic          ovf_q, ovf_d;
  logic          byp_sel_q, byp_sel_d;
  logic [7:0]    byp_data_q;
  logic [7:0]    ram_rdata, front;
  logic          pop_v, full, we;

  urxhp_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (head_q),
    .wdata_i (push_i.data),
    .raddr_i (tail_d),
    .rdata_o (ram_rdata)
  );

  // front entry comes from the ram, or from a write that hit the read address
  assign front = byp_sel_q ? byp_data_q : ram_rdata;

  always_comb begin
    pop_v     = en_i && pop_req_i && (head_q != tail_q);
    tail_d    = pop_v ? ptr_next(tail_q) : tail_q;
    full      = (ptr_next(head_q) == tail_d);
    we        = en_i && push_i.vld && !full;
    head_d    = we ? ptr_next(head_q) : head_q;
    ovf_d     = ovf_q | (en_i && push_i.vld && full);
    byp_sel_d = we && (head_q == tail_d);

    stat_o.pop_valid = pop_v;
    stat_o.pop_byte  = pop_v ? front : 8'h00;
    stat_o.nonempty  = (head_d != tail_d);
    stat_o.overflow  = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      ovf_q     <= 1'b0;
      byp_sel_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      ovf_q     <= ovf_d;
      byp_sel_q <= byp_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= push_i.data;
  end

endmodule

// File: rtl/urxhp_frame.sv
// ---------------------------------------------------------------------------
// urxhp_frame
// rts/cts handshake, bit timing, nine-bit frame and parity check
// ---------------------------------------------------------------------------
module urxhp_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  rx_level_i,
  input  logic                  rts_level_i,
  input  urxhp_pkg::cfg_t       cfg_i,
  output urxhp_pkg::push_t      push_o,
  output urxhp_pkg::frm_stat_t  stat_o
);
  import urxhp_pkg::*;

  typedef enum logic [2:0] {
    PH_START,
    PH_WAIT_RTS,
    PH_IDLE,
    PH_CENTRE,
    PH_DATA,
    PH_STOP,
    PH_TRAP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d, cnt_inc;
  logic [3:0]  bit_idx_q, bit_idx_d;
  logic [7:0]  shift_q, shift_d;
  logic        par_q, par_d, par_n;
  logic        cts_q, cts_d;
  trap_e       trap_q, trap_d;
  logic        perr;
  logic [15:0] full_per, half_per;
  logic        hit_half, hit_full;

  always_comb begin
    full_per = (cfg_i.ticks_per_bit < TPB_MIN) ? TPB_MIN : cfg_i.ticks_per_bit;
    half_per = full_per >> 1;
    cnt_inc  = (cnt_q != CNT_MAX) ? cnt_q + 16'd1 : cnt_q;
    hit_half = (cnt_inc >= half_per);
    hit_full = (cnt_inc >= full_per);
  end

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    par_d     = par_q;
    par_n     = par_q ^ rx_level_i;
    cts_d     = cts_q;
    trap_d    = trap_q;
    perr      = 1'b0;
    push_o    = '{vld: 1'b0, data: shift_q};
    if (en_i) begin
      case (phase_q)
        PH_START: begin
          if (!rx_level_i) begin
            trap_d  = TRAP_RX_LOW;
            phase_d = PH_TRAP;
          end else if (rts_level_i) begin
            trap_d  = TRAP_RTS_HIGH;
            phase_d = PH_TRAP;
          end else begin
            phase_d = PH_WAIT_RTS;
          end
        end
        PH_WAIT_RTS: begin
          if (rts_level_i) begin
            cts_d   = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_IDLE: begin
          if (!rts_level_i) begin
            cts_d   = 1'b0;
            push_o  = '{vld: 1'b1, data: LINE_FEED};
            phase_d = PH_START;
          end else if (!rx_level_i) begin
            cnt_d   = '0;
            phase_d = PH_CENTRE;
          end
        end
        PH_CENTRE: begin
          cnt_d = cnt_inc;
          if (hit_half) begin
            cnt_d     = '0;
            bit_idx_d = '0;
            shift_d   = '0;
            par_d     = 1'b0;
            phase_d   = PH_DATA;
          end
        end
        PH_DATA: begin
          cnt_d = cnt_inc;
          if (hit_full) begin
            cnt_d = '0;
            if (!rts_level_i) begin
              trap_d  = TRAP_RTS_DROP;
              phase_d = PH_TRAP;
            end else begin
              par_d = par_n;
              if (!bit_idx_q[3]) begin
                shift_d[bit_idx_q[2:0]] = rx_level_i;
              end
              bit_idx_d = bit_idx_q + 4'd1;
              if (bit_idx_q >= LAST_BIT) begin
                bit_idx_d = '0;
                shift_d   = shift_d & BYTE_MASK;
                if (par_n != cfg_i.parity_odd) begin
                  perr    = 1'b1;
                  phase_d = PH_IDLE;
                end else begin
                  phase_d = PH_STOP;
                end
              end
            end
          end
        end
        PH_STOP: begin
          cnt_d = cnt_inc;
          if (hit_full) begin
            cnt_d = '0;
            if (!rts_level_i) begin
              trap_d  = TRAP_RTS_DROP;
              phase_d = PH_TRAP;
            end else if (!rx_level_i) begin
              trap_d  = TRAP_BAD_STOP;
              phase_d = PH_TRAP;
            end else begin
              push_o  = '{vld: 1'b1, data: shift_q};
              phase_d = PH_IDLE;
            end
          end
        end
        PH_TRAP: begin
          phase_d = PH_TRAP;
        end
        default: begin
          phase_d = PH_TRAP;
        end
      endcase
    end
    stat_o = '{cts: cts_d, perr: perr, trap: trap_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      cnt_q     <= '0;
      bit_idx_q <= '0;
      shift_q   <= '0;
      par_q     <= 1'b0;
      cts_q     <= 1'b0;
      trap_q    <= TRAP_NONE;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      par_q     <= par_d;
      cts_q     <= cts_d;
      trap_q    <= trap_d;
    end
  end

endmodule

// File: sim/uart_rx_handshake_parity_tb.sv
// ---------------------------------------------------------------------------
// uart_rx_handshake_parity_tb
// self-checking testbench for the uart receiver with rts/cts flow control
// line-sample items are planned against a cycle model of the receiver, which
// also gives the expected result of each item; results are checked field by
// field in order, with random idling on both handshakes, a long receiver
// hold-off, several bit periods and parity senses, fifo overflow, and one
// trap at the end of the run
// ---------------------------------------------------------------------------
module uart_rx_handshake_parity_tb;
  import urxhp_pkg::*;

  localparam int unsigned DEPTH          = FIFO_DEPTH_DEF;
  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    PH_START, PH_WAIT_RTS, PH_IDLE, PH_CENTER, PH_DATA, PH_STOP, PH_TRAP
  } line_phase_e;

  typedef struct packed {
    logic rx;
    logic rts;
    logic pop;
    res_t want;
  } tick_item_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic                  rx_level_i      = 1'b1;
  logic                  rts_level_i     = 1'b0;
  logic                  pop_request_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic                  cts_level_o;
  logic                  pop_valid_o;
  logic [7:0]            pop_byte_o;
  logic                  fifo_nonempty_o;
  logic                  overflow_flag_o;
  logic                  parity_error_o;
  logic [2:0]            trap_code_o;

  uart_rx_handshake_parity dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_level_i     (rx_level_i),
    .rts_level_i    (rts_level_i),
    .pop_request_i  (pop_request_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cts_level_o    (cts_level_o),
    .pop_valid_o    (pop_valid_o),
    .pop_byte_o     (pop_byte_o),
    .fifo_nonempty_o(fifo_nonempty_o),
    .overflow_flag_o(overflow_flag_o),
    .parity_error_o (parity_error_o),
    .trap_code_o    (trap_code_o)
  );

  always #10 clk_i = ~clk_i;

  // receiver model state
  logic [15:0] tpb_cfg;
  logic        odd_cfg;
  line_phase_e ln_phase;
  logic [15:0] ln_cnt;
  logic [3:0]  ln_bit;
  logic [7:0]  ln_shift;
  logic        ln_par;
  logic        ln_cts;
  trap_e       ln_trap;
  logic [7:0]  rxq_mem [DEPTH];
  int unsigned rxq_head;
  int unsigned rxq_tail;
  logic        rxq_ovf;
  logic [8:0]  frame_bits;

  tick_item_t  pend_q[$];
  res_t        exp_q[$];
  res_t        cur_want = '0;

  int unsigned n_acc = 0;
  int unsigned n_res = 0;
  int unsigned n_fail = 0;
  int unsigned n_bytes = 0;
  int unsigned n_perr = 0;
  logic        seen_ovf = 1'b0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm;

  // a stretch with no idling on either side
  assign calm = (n_acc >= 600) && (n_acc < 800);

  function automatic void model_reset();
    tpb_cfg    = TPB_RESET;
    odd_cfg    = 1'b0;
    ln_phase   = PH_START;
    ln_cnt     = '0;
    ln_bit     = '0;
    ln_shift   = '0;
    ln_par     = 1'b0;
    ln_cts     = 1'b0;
    ln_trap    = TRAP_NONE;
    rxq_head   = 0;
    rxq_tail   = 0;
    rxq_ovf    = 1'b0;
    frame_bits = '0;
  endfunction

  function automatic int unsigned bit_period();
    return (tpb_cfg < TPB_MIN) ? TPB_MIN : tpb_cfg;
  endfunction

  function automatic int unsigned count_target();
    return (ln_phase == PH_CENTER) ? (bit_period() >> 1) : bit_period();
  endfunction

  function automatic logic timer_due();
    int unsigned nxt;
    nxt = (ln_cnt < CNT_MAX) ? ln_cnt + 1 : ln_cnt;
    return nxt >= count_target();
  endfunction

  function automatic logic timer_step();
    logic hit;
    hit = timer_due();
    if (hit) ln_cnt = '0;
    else if (ln_cnt < CNT_MAX) ln_cnt = ln_cnt + 1'b1;
    return hit;
  endfunction

  function automatic void rxq_push(logic [7:0] b);
    int unsigned nxt;
    nxt = (rxq_head + 1) % DEPTH;
    if (nxt != rxq_tail) begin
      rxq_mem[rxq_head] = b;
      rxq_head = nxt;
    end else begin
      rxq_ovf = 1'b1;
    end
  endfunction

  // one clock tick of the receiver: pop first, then the line logic
  function automatic res_t line_tick(logic rx, logic rts, logic pop);
    res_t r;
    r = '0;
    if (pop && rxq_head != rxq_tail) begin
      r.pop_valid = 1'b1;
      r.pop_byte  = rxq_mem[rxq_tail];
      rxq_tail    = (rxq_tail + 1) % DEPTH;
    end
    case (ln_phase)
      PH_START: begin
        if (!rx) begin
          ln_trap  = TRAP_RX_LOW;
          ln_phase = PH_TRAP;
        end else if (rts) begin
          ln_trap  = TRAP_RTS_HIGH;
          ln_phase = PH_TRAP;
        end else begin
          ln_phase = PH_WAIT_RTS;
        end
      end
      PH_WAIT_RTS: begin
        if (rts) begin
          ln_cts   = 1'b1;
          ln_phase = PH_IDLE;
        end
      end
      PH_IDLE: begin
        if (!rts) begin
          ln_cts = 1'b0;
          rxq_push(LINE_FEED);
          ln_phase = PH_START;
        end else if (!rx) begin
          ln_cnt   = '0;
          ln_phase = PH_CENTER;
        end
      end
      PH_CENTER: begin
        if (timer_step()) begin
          ln_bit   = '0;
          ln_shift = '0;
          ln_par   = 1'b0;
          ln_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (timer_step()) begin
          if (!rts) begin
            ln_trap  = TRAP_RTS_DROP;
            ln_phase = PH_TRAP;
          end else begin
            ln_par = ln_par ^ rx;
            if (ln_bit < LAST_BIT) ln_shift[ln_bit[2:0]] = rx;
            ln_bit = ln_bit + 1'b1;
            if (ln_bit > LAST_BIT) begin
              ln_bit   = '0;
              ln_shift = ln_shift & BYTE_MASK;
              if (ln_par != odd_cfg) begin
                r.parity_error = 1'b1;
                ln_phase = PH_IDLE;
              end else begin
                ln_phase = PH_STOP;
              end
            end
          end
        end
      end
      PH_STOP: begin
        if (timer_step()) begin
          if (!rts) begin
            ln_trap  = TRAP_RTS_DROP;
            ln_phase = PH_TRAP;
          end else if (!rx) begin
            ln_trap  = TRAP_BAD_STOP;
            ln_phase = PH_TRAP;
          end else begin
            rxq_push(ln_shift);
            ln_phase = PH_IDLE;
          end
        end
      end
      default: ln_phase = PH_TRAP;
    endcase
    r.cts_level     = ln_cts;
    r.fifo_nonempty = (rxq_head != rxq_tail);
    r.overflow_flag = rxq_ovf;
    r.trap_code     = ln_trap;
    return r;
  endfunction

  function automatic logic noisy(logic v);
    return ($urandom_range(7) == 0) ? logic'($urandom_range(1)) : v;
  endfunction

  // well-formed line levels for the modelled phase, with glitches off the
  // sampling points
  task automatic pick_line(input int unsigned drop_pct, input int unsigned start_pct,
                           output logic rx, output logic rts);
    int unsigned roll;
    roll = $urandom_range(99);
    rx   = 1'b1;
    rts  = 1'b1;
    case (ln_phase)
      PH_START: rts = 1'b0;
      PH_WAIT_RTS: begin
        rx  = 1'($urandom_range(1));
        rts = ($urandom_range(1) == 0);
      end
      PH_IDLE: begin
        if (roll < drop_pct) begin
          rts = 1'b0;
          rx  = 1'($urandom_range(1));
        end else if (roll < drop_pct + start_pct) begin
          frame_bits    = 9'($urandom_range(511));
          frame_bits[8] = odd_cfg ^ (^frame_bits[7:0]) ^ ($urandom_range(7) == 0);
          rx = 1'b0;
        end
      end
      PH_CENTER: begin
        rx  = noisy(1'b0);
        rts = noisy(1'b1);
      end
      PH_DATA, PH_STOP: begin
        rx = (ln_phase == PH_STOP) ? 1'b1 : frame_bits[ln_bit];
        if (!timer_due()) begin
          rx  = noisy(rx);
          rts = noisy(1'b1);
        end
      end
      default: begin
        rx  = 1'($urandom_range(1));
        rts = 1'($urandom_range(1));
      end
    endcase
  endtask

  task automatic plan_tick(input logic rx, input logic rts, input logic pop);
    tick_item_t it;
    it.rx   = rx;
    it.rts  = rts;
    it.pop  = pop;
    it.want = line_tick(rx, rts, pop);
    pend_q.push_back(it);
  endtask

  task automatic plan_run(input int unsigned n, input int unsigned pop_pct,
                          input int unsigned drop_pct, input int unsigned start_pct);
    logic rx, rts;
    repeat (n) begin
      pick_line(drop_pct, start_pct, rx, rts);
      plan_tick(rx, rts, $urandom_range(99) < pop_pct);
    end
  endtask

  task automatic plan_trap(input trap_e code);
    logic rx, rts;
    if (code == TRAP_RX_LOW || code == TRAP_RTS_HIGH) begin
      while (ln_phase != PH_START) begin
        pick_line(100, 0, rx, rts);
        plan_tick(rx, rts, 1'b0);
      end
      plan_tick(code == TRAP_RTS_HIGH, code == TRAP_RTS_HIGH, 1'b0);
    end else begin
      while (!(ln_phase == PH_STOP && timer_due())) begin
        pick_line(0, 100, rx, rts);
        plan_tick(rx, rts, 1'b0);
      end
      plan_tick(code == TRAP_RTS_DROP, code == TRAP_BAD_STOP, 1'b0);
    end
  endtask

  task automatic wait_drain();
    while (pend_q.size() != 0 || in_valid_i || exp_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TICKS_PER_BIT) tpb_cfg = val;
    else if (idx == REG_PARITY_ODD) odd_cfg = val[0];
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      n_fail++;
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    tick_item_t it;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      rx_level_i    <= 1'b1;
      rts_level_i   <= 1'b0;
      pop_request_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        exp_q.push_back(cur_want);
        n_acc++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pend_q.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
          it = pend_q.pop_front();
          in_valid_i    <= 1'b1;
          rx_level_i    <= it.rx;
          rts_level_i   <= it.rts;
          pop_request_i <= it.pop;
          cur_want      <= it.want;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_res++;
        if (exp_q.size() == 0) begin
          $display("%0t: result with no item pending", $time);
          n_fail++;
        end else begin
          want = exp_q.pop_front();
          check_field("cts_level", want.cts_level, cts_level_o);
          check_field("pop_valid", want.pop_valid, pop_valid_o);
          check_field("pop_byte", want.pop_byte, pop_byte_o);
          check_field("fifo_nonempty", want.fifo_nonempty, fifo_nonempty_o);
          check_field("overflow_flag", want.overflow_flag, overflow_flag_o);
          check_field("parity_error", want.parity_error, parity_error_o);
          check_field("trap_code", want.trap_code, trap_code_o);
          n_bytes  += want.pop_valid;
          n_perr   += want.parity_error;
          seen_ovf |= want.overflow_flag;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && n_res >= 300) begin
        // long hold-off so that the output stage fills and stalls the input
        hold_done = 1'b1;
        hold_left = 150;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 18);
      end
    end
  end

  initial begin
    logic  rx, rts;
    trap_e end_trap;
    model_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: short bit period, handshake, line feed, pop on empty,
    // top byte with bit 7 cleared, pop and push in one tick
    write_reg(REG_TICKS_PER_BIT, 16'd0);
    write_reg(REG_UNUSED, '1);
    plan_tick(1'b1, 1'b0, 1'b1);
    plan_tick(1'b0, 1'b0, 1'b0);
    plan_tick(1'b1, 1'b1, 1'b0);
    plan_tick(1'b0, 1'b0, 1'b0);
    plan_tick(1'b1, 1'b0, 1'b0);
    plan_tick(1'b1, 1'b1, 1'b0);
    frame_bits = {1'b0, 8'hFF};
    plan_tick(1'b0, 1'b1, 1'b0);
    while (ln_phase == PH_CENTER || ln_phase == PH_DATA || ln_phase == PH_STOP) begin
      pick_line(0, 0, rx, rts);
      plan_tick(rx, rts, ln_phase == PH_STOP);
    end
    plan_tick(1'b1, 1'b1, 1'b1);
    plan_tick(1'b1, 1'b1, 1'b1);
    wait_drain();

    write_reg(REG_TICKS_PER_BIT, 16'd2);
    write_reg(REG_PARITY_ODD, 16'd0);
    plan_run(200, 50, 5, 30);
    wait_drain();

    // mostly rts drops with rare pops, to fill the fifo past full
    write_reg(REG_TICKS_PER_BIT, 16'd1);
    write_reg(REG_PARITY_ODD, 16'd1);
    plan_run(500, 1, 80, 5);
    wait_drain();

    // longest bit period: sit part way into the start bit, then shorten it
    while (ln_phase != PH_CENTER) begin
      pick_line(0, 100, rx, rts);
      plan_tick(rx, rts, 1'b0);
    end
    wait_drain();
    write_reg(REG_TICKS_PER_BIT, 16'hFFFF);
    plan_run(30, 50, 0, 0);
    wait_drain();
    write_reg(REG_TICKS_PER_BIT, 16'd3);
    plan_run(200, 50, 5, 30);
    wait_drain();

    write_reg(REG_TICKS_PER_BIT, 16'($urandom_range(6, 2)));
    write_reg(REG_PARITY_ODD, 16'($urandom_range(1)));
    plan_run(250, 30, 5, 30);
    wait_drain();

    // the receiver stays trapped until reset, so the trap comes last
    end_trap = trap_e'($urandom_range(4, 1));
    plan_trap(end_trap);
    plan_run(40, 50, 0, 0);
    wait_drain();
    repeat (10) @(posedge clk_i);

    $display("%0d items checked, %0d bytes popped, %0d parity drops", n_res, n_bytes, n_perr);
    $display("fifo overflow reached: %0d, final trap code %0d", seen_ovf, end_trap);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("timeout with %0d results still expected", exp_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/urxhp_pkg.sv
rtl/urxhp_ram.sv
rtl/urxhp_fifo.sv
rtl/urxhp_frame.sv
rtl/uart_rx_handshake_parity.sv
sim/uart_rx_handshake_parity_tb.sv
